### hdl/corq_pkg.sv
// Shared types and constants for the credit-ordered ready queue.
package corq_pkg;

  localparam int QueueEntries = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CHANGE = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] thread_id;
    logic [7:0] credit;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] thread_credit;
    logic       head_valid;
    logic [7:0] head_thread;
    logic [7:0] head_credit;
    logic [5:0] entry_count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_REPORT,
    S_OUT
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic shift_step;
    logic report_start;
    logic report_step;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic report_done;
  } dp_status_t;

endpackage

### hdl/corq_ctrl.sv
// Controller state machine sequencing scan, shift and report phases.
module corq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  res_valid,
  input  logic                  res_ready,
  input  corq_pkg::dp_status_t  stat,
  output corq_pkg::dp_cmd_t     cmd
);

  corq_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= corq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    case (state)
      corq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = corq_pkg::S_SCAN;
        end
      end
      corq_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = corq_pkg::S_SHIFT;
        end
      end
      corq_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          cmd.report_start = 1'b1;
          state_next = corq_pkg::S_REPORT;
        end
      end
      corq_pkg::S_REPORT: begin
        cmd.report_step = 1'b1;
        if (stat.report_done) begin
          cmd.finish = 1'b1;
          state_next = corq_pkg::S_OUT;
        end
      end
      corq_pkg::S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = corq_pkg::S_IDLE;
        end
      end
      default: state_next = corq_pkg::S_IDLE;
    endcase
  end

endmodule

### hdl/corq_datapath.sv
// Datapath holding the sorted entry registers, scan index and result register.
module corq_datapath #(
  parameter int QUEUE_ENTRIES = corq_pkg::QueueEntries
) (
  input  logic                  clk,
  input  logic                  rst,
  input  corq_pkg::request_t    req,
  input  corq_pkg::dp_cmd_t     cmd,
  output corq_pkg::dp_status_t  stat,
  output corq_pkg::result_t     res
);

  localparam int IW = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
  localparam int CW = $clog2(QUEUE_ENTRIES + 1);

  // Entries are held in registers; in the shift step each slot keeps its value,
  // takes the new entry, or copies a fixed neighbor above or below.
  logic [7:0] slot_thread         [QUEUE_ENTRIES];
  logic [7:0] slot_create_credit  [QUEUE_ENTRIES];
  logic [7:0] slot_current_credit [QUEUE_ENTRIES];
  logic [CW-1:0] held_count;

  corq_pkg::request_t r;
  logic [CW-1:0] idx;
  logic [CW-1:0] found_idx;
  logic          found;
  logic [CW-1:0] pos;
  logic          pos_set;
  logic [7:0]    found_create;
  logic [1:0]    status;
  logic [7:0]    tcredit;
  logic          tfound;

  logic          in_range;
  logic [IW-1:0] idx_a;
  logic          full;

  assign in_range = idx < held_count;
  assign idx_a = idx[IW-1:0];
  assign full = held_count == CW'(QUEUE_ENTRIES);
  assign stat.scan_done = !in_range;
  assign stat.shift_done = 1'b1;
  assign stat.report_done = !in_range || tfound;

  // Position for placing: after the removed entry closes, slots above it
  // move down one; the placement index is counted on the pre-removal array.
  logic [7:0] place_credit;
  assign place_credit = r.credit;

  logic [CW-1:0] held_count_next;
  logic do_drop, do_place;
  logic [CW-1:0] ins_pos;
  logic [7:0]    ins_create;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.shift_step) begin
      held_count <= held_count_next;
    end
  end

  always_comb begin
    do_drop = 1'b0;
    do_place = 1'b0;
    status = corq_pkg::ST_DONE;
    ins_pos = pos;
    ins_create = r.credit;
    case (r.action)
      corq_pkg::ACT_INSERT: begin
        if (full) status = corq_pkg::ST_FULL;
        else do_place = 1'b1;
      end
      corq_pkg::ACT_REMOVE: begin
        if (!found) status = corq_pkg::ST_NOT_FOUND;
        else do_drop = 1'b1;
      end
      corq_pkg::ACT_CHANGE: begin
        if (!found) status = corq_pkg::ST_NOT_FOUND;
        else begin
          do_drop = 1'b1;
          do_place = 1'b1;
          ins_create = found_create;
          if (pos > found_idx) ins_pos = pos - CW'(1);
        end
      end
      default: begin
        if (!found) status = corq_pkg::ST_NOT_FOUND;
      end
    endcase
    held_count_next = held_count - CW'(do_drop) + CW'(do_place);
  end

  // Shift: each slot takes the value of itself, a neighbor or the new entry.
  // Status above refers to pre-shift state, so it is latched at shift time.
  logic [1:0] status_q;
  always_ff @(posedge clk) begin
    if (cmd.shift_step) status_q <= status;
  end

  // Scan: find the first matching id and the placement index in one pass.
  // Placement index counts entries other than the dropped one whose credit
  // is at least the new credit, since the list stays sorted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= req;
    end
    if (cmd.scan_start) begin
      idx <= '0;
      found <= 1'b0;
      pos_set <= 1'b0;
      pos <= '0;
      found_idx <= '0;
      found_create <= '0;
    end else if (cmd.scan_step && in_range) begin
      idx <= idx + CW'(1);
      if (!found && slot_thread[idx_a] == r.thread_id && r.action != corq_pkg::ACT_INSERT)
      begin
        found <= 1'b1;
        found_idx <= idx;
        found_create <= slot_create_credit[idx_a];
        if (!pos_set) pos <= idx + CW'(1);
      end else if (!pos_set) begin
        if (slot_current_credit[idx_a] >= place_credit) pos <= idx + CW'(1);
        else pos_set <= 1'b1;
      end
    end
    if (cmd.report_start) begin
      idx <= '0;
      tfound <= 1'b0;
      tcredit <= '0;
    end else if (cmd.report_step && in_range && !tfound) begin
      idx <= idx + CW'(1);
      if (slot_thread[idx_a] == r.thread_id) begin
        tfound <= 1'b1;
        tcredit <= slot_current_credit[idx_a];
      end
    end
    if (cmd.finish) begin
      res.status <= status_q;
      res.thread_credit <= tcredit;
      res.head_valid <= held_count != '0;
      res.head_thread <= (held_count != '0) ? slot_thread[0] : 8'd0;
      res.head_credit <= (held_count != '0) ? slot_current_credit[0] : 8'd0;
      res.entry_count <= 6'(held_count);
    end
  end

  for (genvar k = 0; k < QUEUE_ENTRIES; k++) begin : g_slot
    localparam int KN = (k + 1 < QUEUE_ENTRIES) ? k + 1 : k;
    localparam int KP = (k > 0) ? k - 1 : 0;
    logic [CW-1:0] kk;
    logic [CW-1:0] src;
    logic          src_new;
    assign kk = CW'(k);
    always_comb begin
      // Source index in the pre-shift array; ins_pos counts after the drop, before the place.
      src_new = 1'b0;
      src = kk;
      if (do_place && kk == ins_pos) begin
        src_new = 1'b1;
      end else begin
        if (do_place && kk > ins_pos) src = kk - CW'(1);
        if (do_drop && src >= found_idx) src = src + CW'(1);
      end
    end
    always_ff @(posedge clk) begin
      if (cmd.shift_step) begin
        if (src_new) begin
          slot_thread[k] <= r.thread_id;
          slot_create_credit[k] <= ins_create;
          slot_current_credit[k] <= r.credit;
        end else if (src == kk + CW'(1)) begin
          slot_thread[k] <= slot_thread[KN];
          slot_create_credit[k] <= slot_create_credit[KN];
          slot_current_credit[k] <= slot_current_credit[KN];
        end else if (src != kk) begin
          slot_thread[k] <= slot_thread[KP];
          slot_create_credit[k] <= slot_create_credit[KP];
          slot_current_credit[k] <= slot_current_credit[KP];
        end
      end
    end
  end

endmodule

### hdl/credit_ordered_ready_queue.sv
// Top level of the credit-ordered ready queue.
// Takes one request at a time: a new request is accepted only after the result is taken.
// Each request runs a linear scan over the held entries, a shift, and a report walk
// over the entries that stops at the matching thread.
// Reset clears the controller and the count; entry contents need no reset.
module credit_ordered_ready_queue #(
  parameter int QUEUE_ENTRIES = corq_pkg::QueueEntries
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  corq_pkg::request_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output corq_pkg::result_t  out_data
);

  corq_pkg::dp_cmd_t    cmd;
  corq_pkg::dp_status_t stat;

  corq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  corq_datapath #(
    .QUEUE_ENTRIES (QUEUE_ENTRIES)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (in_data),
    .cmd  (cmd),
    .stat (stat),
    .res  (out_data)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("request taken while result pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count <= 6'(QUEUE_ENTRIES))
    else $error("count exceeds depth");

  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.head_valid) |-> out_data.entry_count == 6'd0)
    else $error("head flag disagrees with count");

endmodule
